// ===== src/tfdn_pkg.sv =====
// Shared constants, types and command structures of the thermal frame deframer.
package tfdn_pkg;

    localparam int FRAME_ROWS    = 24;
    localparam int FRAME_COLS    = 32;
    localparam int HEADER_BYTES  = 4;
    localparam int TRAILER_BYTES = 2;

    localparam int PIXEL_BYTES   = 2 * FRAME_ROWS * FRAME_COLS;
    localparam int AMBIENT_START = HEADER_BYTES + PIXEL_BYTES;
    localparam int FRAME_BYTES   = AMBIENT_START + 2 + TRAILER_BYTES;
    localparam int POS_W         = $clog2(FRAME_BYTES);

    localparam int IDX_W         = 8;
    localparam int ROW_W         = 5;
    localparam int COL_W         = 5;
    localparam int TEMP_W        = 16;
    localparam int GRAY_W        = 8;
    localparam int NUM_W         = TEMP_W + GRAY_W;
    localparam int STEP_W        = $clog2(GRAY_W);

    localparam logic [GRAY_W-1:0]        GRAY_MAX     = '1;
    localparam logic signed [TEMP_W-1:0] TEMP_LOW_RST = 16'sd2000;
    localparam logic signed [TEMP_W-1:0] TEMP_HIGH_RST = 16'sd4000;
    localparam logic signed [TEMP_W-1:0] MIN_RST      = 16'sh7FFF;
    localparam logic signed [TEMP_W-1:0] MAX_RST      = 16'sh8000;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic REG_TEMP_LOW  = 1'b0;
    localparam logic REG_TEMP_HIGH = 1'b1;

    localparam logic KIND_PIXEL   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        BC_SKIP,
        BC_LOW,
        BC_PIXEL,
        BC_AMBIENT
    } t_byte_class;

    typedef struct packed {
        logic take;
        logic prep;
        logic sat_check;
        logic div_step;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        t_byte_class byte_class;
        logic        out_free;
    } t_dp_status;

endpackage

// ===== src/tfdn_ctrl.sv =====
// Sequencing state machine for byte intake, gray division and result issue.
module tfdn_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  tfdn_pkg::t_dp_status i_status,
    output tfdn_pkg::t_ctrl_cmd  o_cmd,
    output logic                o_busy
);
    import tfdn_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SAT,
        ST_DIV,
        ST_EMIT
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.take = i_valid;
                if (i_valid) begin
                    unique case (i_status.byte_class)
                        BC_PIXEL:   n_state = ST_PREP;
                        BC_AMBIENT: n_state = ST_EMIT;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = ST_SAT;
            end
            ST_SAT: begin
                o_cmd.sat_check = 1'b1;
                n_step          = STEP_W'(GRAY_W - 1);
                n_state         = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step - 1'b1;
                if (r_step == '0) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_cmd.load_out = i_status.out_free;
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

// ===== src/tfdn_datapath.sv =====
// Frame position tracking, word assembly, extremes, gray divider and result register.
module tfdn_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tfdn_pkg::t_ctrl_cmd             i_cmd,
    output tfdn_pkg::t_dp_status            o_status,
    input  logic [7:0]                      i_rx_byte,
    input  logic signed [tfdn_pkg::TEMP_W-1:0] i_temp_low,
    input  logic signed [tfdn_pkg::TEMP_W-1:0] i_temp_high,
    input  logic                            i_stall,
    output logic                            o_valid,
    output logic                            o_result_kind,
    output logic [tfdn_pkg::ROW_W-1:0]      o_pixel_row,
    output logic [tfdn_pkg::COL_W-1:0]      o_pixel_column,
    output logic signed [tfdn_pkg::TEMP_W-1:0] o_pixel_temp,
    output logic [tfdn_pkg::GRAY_W-1:0]     o_gray_level,
    output logic signed [tfdn_pkg::TEMP_W-1:0] o_frame_min,
    output logic signed [tfdn_pkg::TEMP_W-1:0] o_frame_max,
    output logic [tfdn_pkg::TEMP_W-1:0]     o_ambient_temp,
    output logic                            o_frame_done
);
    import tfdn_pkg::*;

    logic [POS_W-1:0]         r_pos;
    logic [POS_W-1:0]         pos_off;
    t_byte_class              byte_class;
    logic [7:0]               r_held;
    logic [TEMP_W-1:0]        word;
    logic [TEMP_W-1:0]        r_word;
    logic                     r_kind;
    logic signed [TEMP_W-1:0] r_min;
    logic signed [TEMP_W-1:0] r_max;
    logic [IDX_W-1:0]         r_row;
    logic [IDX_W-1:0]         r_col;
    logic [IDX_W-1:0]         r_pix_row;
    logic [IDX_W-1:0]         r_pix_col;

    logic signed [TEMP_W:0]   diff;
    logic signed [TEMP_W:0]   span;
    logic signed [NUM_W:0]    num;
    logic [NUM_W-1:0]         r_num;
    logic [TEMP_W-1:0]        r_span;
    logic                     r_zero;
    logic                     r_sat;
    logic [NUM_W-1:0]         r_rem;
    logic [NUM_W-2:0]         r_dvs;
    logic [GRAY_W-1:0]        r_q;
    logic [GRAY_W-1:0]        gray;

    logic                     r_out_valid;
    logic                     out_free;

    assign pos_off = r_pos - POS_W'(HEADER_BYTES);
    assign word    = {i_rx_byte, r_held};

    always_comb begin
        byte_class = BC_SKIP;
        if ({1'b0, r_pos} < (POS_W + 1)'(HEADER_BYTES)) begin
            byte_class = BC_SKIP;
        end else if ({1'b0, r_pos} < (POS_W + 1)'(AMBIENT_START + 2)) begin
            if (!pos_off[0]) begin
                byte_class = BC_LOW;
            end else if ({1'b0, r_pos} < (POS_W + 1)'(AMBIENT_START)) begin
                byte_class = BC_PIXEL;
            end else begin
                byte_class = BC_AMBIENT;
            end
        end
    end

    assign out_free            = !r_out_valid || !i_stall;
    assign o_status.byte_class = byte_class;
    assign o_status.out_free   = out_free;

    assign diff = $signed({r_word[TEMP_W-1], r_word})
                - $signed({i_temp_low[TEMP_W-1], i_temp_low});
    assign span = $signed({i_temp_high[TEMP_W-1], i_temp_high})
                - $signed({i_temp_low[TEMP_W-1], i_temp_low});
    assign num  = ($signed({{(NUM_W - TEMP_W){diff[TEMP_W]}}, diff}) <<< GRAY_W)
                - $signed({{(NUM_W - TEMP_W){diff[TEMP_W]}}, diff});

    assign gray = r_zero ? '0 : (r_sat ? GRAY_MAX : r_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_held <= '0;
            r_min  <= MIN_RST;
            r_max  <= MAX_RST;
            r_row  <= '0;
            r_col  <= '0;
        end else begin
            if (i_cmd.take) begin
                r_pos <= (r_pos == POS_W'(FRAME_BYTES - 1)) ? '0 : r_pos + 1'b1;
                unique case (byte_class)
                    BC_LOW: begin
                        r_held <= i_rx_byte;
                    end
                    BC_PIXEL: begin
                        if ($signed(word) < r_min) begin
                            r_min <= $signed(word);
                        end
                        if ($signed(word) > r_max) begin
                            r_max <= $signed(word);
                        end
                        if (r_col == IDX_W'(FRAME_COLS - 1)) begin
                            r_col <= '0;
                            r_row <= (r_row == IDX_W'(FRAME_ROWS - 1)) ? '0 : r_row + 1'b1;
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.load_out && r_kind == KIND_SUMMARY) begin
                r_min <= MIN_RST;
                r_max <= MAX_RST;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && (byte_class == BC_PIXEL || byte_class == BC_AMBIENT)) begin
            r_word    <= word;
            r_kind    <= (byte_class == BC_AMBIENT) ? KIND_SUMMARY : KIND_PIXEL;
            r_pix_row <= r_row;
            r_pix_col <= r_col;
        end
        if (i_cmd.prep) begin
            r_num  <= num[NUM_W-1:0];
            r_span <= span[TEMP_W-1:0];
            r_zero <= (span <= 0) || diff[TEMP_W];
        end
        if (i_cmd.sat_check) begin
            r_sat <= (r_num >= {r_span, {GRAY_W{1'b0}}});
            r_rem <= r_num;
            r_dvs <= {r_span, {(GRAY_W - 1){1'b0}}};
            r_q   <= '0;
        end
        if (i_cmd.div_step) begin
            if ({1'b0, r_dvs} <= r_rem) begin
                r_rem <= r_rem - {1'b0, r_dvs};
                r_q   <= {r_q[GRAY_W-2:0], 1'b1};
            end else begin
                r_q   <= {r_q[GRAY_W-2:0], 1'b0};
            end
            r_dvs <= r_dvs >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_result_kind <= r_kind;
            if (r_kind == KIND_SUMMARY) begin
                o_pixel_row    <= '0;
                o_pixel_column <= '0;
                o_pixel_temp   <= '0;
                o_gray_level   <= '0;
                o_frame_min    <= r_min;
                o_frame_max    <= r_max;
                o_ambient_temp <= r_word;
                o_frame_done   <= 1'b1;
            end else begin
                o_pixel_row    <= r_pix_row[ROW_W-1:0];
                o_pixel_column <= r_pix_col[COL_W-1:0];
                o_pixel_temp   <= $signed(r_word);
                o_gray_level   <= gray;
                o_frame_min    <= '0;
                o_frame_max    <= '0;
                o_ambient_temp <= '0;
                o_frame_done   <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;

endmodule

// ===== src/thermal_frame_deframe_normalize.sv =====
// Top level of the thermal frame deframer and normaliser with its register port.
//
// Channel   | Direction | Handshake           | Word
// ----------+-----------+---------------------+------------------------------------
// input     | in        | i_valid / o_stall   | i_rx_byte
// output    | out       | o_valid / i_stall   | kind, row, column, temp, gray, summary
// register  | in/out    | psel/penable/pready | pwdata, prdata at paddr
//
// A pixel high byte passes through intake, scaling, range check, eight
// restoring divider steps of one quotient bit each, and the load of the result register.
// Every other byte needs intake only; the summary word adds the load of the result register.
// A waiting result does not block intake; only the load into a full result register stalls.
// Reset is synchronous and active low; it clears the frame position and the extremes.
module thermal_frame_deframe_normalize (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [7:0]                           i_rx_byte,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic                                 o_result_kind,
    output logic [tfdn_pkg::ROW_W-1:0]           o_pixel_row,
    output logic [tfdn_pkg::COL_W-1:0]           o_pixel_column,
    output logic signed [tfdn_pkg::TEMP_W-1:0]   o_pixel_temp,
    output logic [tfdn_pkg::GRAY_W-1:0]          o_gray_level,
    output logic signed [tfdn_pkg::TEMP_W-1:0]   o_frame_min,
    output logic signed [tfdn_pkg::TEMP_W-1:0]   o_frame_max,
    output logic [tfdn_pkg::TEMP_W-1:0]          o_ambient_temp,
    output logic                                 o_frame_done,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tfdn_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [tfdn_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [tfdn_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);
    import tfdn_pkg::*;

    logic signed [TEMP_W-1:0] r_temp_low;
    logic signed [TEMP_W-1:0] r_temp_high;
    logic                     reg_sel;
    t_ctrl_cmd                cmd;
    t_dp_status               status;
    logic                     busy;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_low  <= TEMP_LOW_RST;
            r_temp_high <= TEMP_HIGH_RST;
        end else if (psel && penable && pwrite) begin
            unique case (reg_sel)
                REG_TEMP_LOW:  r_temp_low  <= $signed(pwdata[TEMP_W-1:0]);
                REG_TEMP_HIGH: r_temp_high <= $signed(pwdata[TEMP_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_TEMP_LOW:  prdata = {{(APB_DATA_W - TEMP_W){1'b0}}, r_temp_low};
            REG_TEMP_HIGH: prdata = {{(APB_DATA_W - TEMP_W){1'b0}}, r_temp_high};
            default:       prdata = '0;
        endcase
    end

    tfdn_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    tfdn_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_rx_byte      (i_rx_byte),
        .i_temp_low     (r_temp_low),
        .i_temp_high    (r_temp_high),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_result_kind  (o_result_kind),
        .o_pixel_row    (o_pixel_row),
        .o_pixel_column (o_pixel_column),
        .o_pixel_temp   (o_pixel_temp),
        .o_gray_level   (o_gray_level),
        .o_frame_min    (o_frame_min),
        .o_frame_max    (o_frame_max),
        .o_ambient_temp (o_ambient_temp),
        .o_frame_done   (o_frame_done)
    );

    assign o_stall = busy;

endmodule

// ===== src/tfdn_checker.sv =====
// Port-level checks on the result channel of the thermal frame deframer.
module tfdn_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_valid,
    input logic                               i_stall,
    input logic                               o_result_kind,
    input logic signed [tfdn_pkg::TEMP_W-1:0] o_pixel_temp,
    input logic [tfdn_pkg::GRAY_W-1:0]        o_gray_level,
    input logic [tfdn_pkg::TEMP_W-1:0]        o_ambient_temp,
    input logic                               o_frame_done
);
    import tfdn_pkg::*;

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_done_marks_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_frame_done == o_result_kind))
        else $error("frame done does not match result kind");

    a_summary_pixel_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_kind == KIND_SUMMARY) |-> (o_pixel_temp == '0 && o_gray_level == '0))
        else $error("summary word carries pixel fields");

    a_pixel_ambient_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_kind == KIND_PIXEL) |-> (o_ambient_temp == '0))
        else $error("pixel word carries ambient field");

    a_stalled_word_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_pixel_temp) && $stable(o_gray_level)))
        else $error("stalled result word changed");

endmodule

bind thermal_frame_deframe_normalize tfdn_checker u_tfdn_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_result_kind  (o_result_kind),
    .o_pixel_temp   (o_pixel_temp),
    .o_gray_level   (o_gray_level),
    .o_ambient_temp (o_ambient_temp),
    .o_frame_done   (o_frame_done)
);

// ===== verif/tb_thermal_frame_deframe_normalize.sv =====
`timescale 1ns / 1ps
// Self-checking testbench that streams sensor frame words into the deframer and checks every result.
module tb_thermal_frame_deframe_normalize;
    import tfdn_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [4:0]  row;
        logic [4:0]  column;
        logic [15:0] temp;
        logic [7:0]  gray;
        logic [15:0] low_temp;
        logic [15:0] high_temp;
        logic [15:0] ambient;
        logic        done;
    } t_frame_result;

    localparam int STREAM_END = 850;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    logic [7:0]                    i_rx_byte;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic                          o_result_kind;
    logic [ROW_W-1:0]              o_pixel_row;
    logic [COL_W-1:0]              o_pixel_column;
    logic signed [TEMP_W-1:0]      o_pixel_temp;
    logic [GRAY_W-1:0]             o_gray_level;
    logic signed [TEMP_W-1:0]      o_frame_min;
    logic signed [TEMP_W-1:0]      o_frame_max;
    logic [TEMP_W-1:0]             o_ambient_temp;
    logic                          o_frame_done;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [APB_ADDR_W-1:0]         paddr;
    logic [APB_DATA_W-1:0]         pwdata;
    logic [APB_DATA_W-1:0]         prdata;
    logic                          pready;

    t_frame_result                 pending_results[$];
    t_frame_result                 oldest;
    int                            mismatch_count = 0;
    int                            bytes_sent = 0;
    int                            sender_idle_pct = 0;
    int                            receiver_stall_pct = 0;
    logic                          holdoff_request = 1'b0;
    int                            holdoff_left = 0;

    int                            frame_pos = 0;
    logic [7:0]                    held_byte = 8'h00;
    logic signed [15:0]            frame_lo = MIN_RST;
    logic signed [15:0]            frame_hi = MAX_RST;
    logic signed [15:0]            cfg_low = TEMP_LOW_RST;
    logic signed [15:0]            cfg_high = TEMP_HIGH_RST;

    thermal_frame_deframe_normalize DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_kind  (o_result_kind),
        .o_pixel_row    (o_pixel_row),
        .o_pixel_column (o_pixel_column),
        .o_pixel_temp   (o_pixel_temp),
        .o_gray_level   (o_gray_level),
        .o_frame_min    (o_frame_min),
        .o_frame_max    (o_frame_max),
        .o_ambient_temp (o_ambient_temp),
        .o_frame_done   (o_frame_done),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic t_byte_class classify_position(input int pos);
        if (pos < HEADER_BYTES || pos >= AMBIENT_START + 2) begin
            return BC_SKIP;
        end
        if (((pos - HEADER_BYTES) % 2) == 0) begin
            return BC_LOW;
        end
        if (pos < AMBIENT_START) begin
            return BC_PIXEL;
        end
        return BC_AMBIENT;
    endfunction

    function automatic logic [7:0] scale_to_gray(input logic signed [15:0] t);
        int span;
        int num;
        span = int'(cfg_high) - int'(cfg_low);
        num = (int'(t) - int'(cfg_low)) * 255;
        if (span <= 0 || num < 0) begin
            return 8'd0;
        end
        if (num / span > 255) begin
            return GRAY_MAX;
        end
        return 8'(num / span);
    endfunction

    function automatic void queue_expected(input t_frame_result r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic void deframe_predict(input logic [7:0] b);
        t_byte_class   cls;
        logic [15:0]   word;
        int            idx;
        t_frame_result r;
        cls = classify_position(frame_pos);
        idx = (frame_pos - HEADER_BYTES) / 2;
        frame_pos = (frame_pos + 1 >= FRAME_BYTES) ? 0 : frame_pos + 1;
        word = {b, held_byte};
        r = '0;
        case (cls)
            BC_LOW: begin
                held_byte = b;
            end
            BC_PIXEL: begin
                if ($signed(word) < frame_lo) begin
                    frame_lo = word;
                end
                if ($signed(word) > frame_hi) begin
                    frame_hi = word;
                end
                r.kind = KIND_PIXEL;
                r.row = 5'(idx / FRAME_COLS);
                r.column = 5'(idx % FRAME_COLS);
                r.temp = word;
                r.gray = scale_to_gray(word);
                queue_expected(r);
            end
            BC_AMBIENT: begin
                r.kind = KIND_SUMMARY;
                r.low_temp = frame_lo;
                r.high_temp = frame_hi;
                r.ambient = word;
                r.done = 1'b1;
                queue_expected(r);
                frame_lo = MIN_RST;
                frame_hi = MAX_RST;
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void check_field(input string label, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h, actual %0h", $time, label, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (holdoff_request) begin
            holdoff_left = 300;
            holdoff_request = 1'b0;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result word with nothing expected, actual kind %0h temp %0h",
                         $time, o_result_kind, o_pixel_temp);
                mismatch_count++;
            end else begin
                oldest = pending_results.pop_front();
                check_field("result_kind", 16'(oldest.kind), 16'(o_result_kind));
                check_field("pixel_row", 16'(oldest.row), 16'(o_pixel_row));
                check_field("pixel_column", 16'(oldest.column), 16'(o_pixel_column));
                check_field("pixel_temp", oldest.temp, o_pixel_temp);
                check_field("gray_level", 16'(oldest.gray), 16'(o_gray_level));
                check_field("frame_min", oldest.low_temp, o_frame_min);
                check_field("frame_max", oldest.high_temp, o_frame_max);
                check_field("ambient_temp", oldest.ambient, o_ambient_temp);
                check_field("frame_done", 16'(oldest.done), 16'(o_frame_done));
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        deframe_predict(b);
        bytes_sent++;
    endtask

    task automatic send_temp(input logic [15:0] t);
        send_byte(t[7:0]);
        send_byte(t[15:8]);
    endtask

    task automatic reg_access(input logic idx, input logic is_write, input logic [15:0] v);
        logic [15:0] held_value;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= is_write;
        paddr <= {idx, 2'b00};
        pwdata <= {{16{v[15]}}, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        held_value = (idx == REG_TEMP_LOW) ? cfg_low : cfg_high;
        if (is_write) begin
            if (idx == REG_TEMP_LOW) begin
                cfg_low = v;
            end else begin
                cfg_high = v;
            end
        end else if (prdata[15:0] !== held_value) begin
            $display("%0t: register %0d expected %0h, actual %0h",
                     $time, idx, held_value, prdata[15:0]);
            mismatch_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_span(input int lo, input int hi);
        reg_access(REG_TEMP_LOW, 1'b1, 16'(lo));
        reg_access(REG_TEMP_HIGH, 1'b1, 16'(hi));
        reg_access(REG_TEMP_LOW, 1'b0, 16'h0000);
        reg_access(REG_TEMP_HIGH, 1'b0, 16'h0000);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_temp();
        int t;
        int span;
        span = int'(cfg_high) - int'(cfg_low);
        case ($urandom_range(3))
            0: t = int'($urandom_range(65535)) - 32768;
            1: t = (span > 0) ? int'(cfg_low) + int'($urandom_range(span)) : int'(cfg_low);
            2: t = int'(cfg_low) + int'($urandom_range(40)) - 20;
            default: t = int'(cfg_high) + int'($urandom_range(40)) - 20;
        endcase
        if (t > 32767) begin
            t = 32767;
        end
        if (t < -32768) begin
            t = -32768;
        end
        return 16'(t);
    endfunction

    task automatic stream_frames(input int last_byte);
        while (bytes_sent < last_byte) begin
            if (classify_position(frame_pos) == BC_LOW && frame_pos < AMBIENT_START &&
                bytes_sent + 2 <= last_byte) begin
                send_temp(pick_temp());
            end else begin
                send_byte(8'($urandom_range(255)));
            end
        end
    endtask

    task automatic test_register_defaults();
        reg_access(REG_TEMP_LOW, 1'b0, 16'h0000);
        reg_access(REG_TEMP_HIGH, 1'b0, 16'h0000);
    endtask

    task automatic test_directed_pixels();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_temp(16'h7FFF);
        send_temp(16'h8000);
        send_temp(16'd2000);
        send_temp(16'd4000);
        send_temp(16'd3000);
        send_temp(16'd1999);
        send_temp(16'd4001);
        send_temp(16'd2008);
    endtask

    task automatic test_span_edges();
        settle();
        set_span(-32768, 32767);
        send_temp(16'h7FFF);
        send_temp(16'h8000);
        send_temp(16'h0000);
        settle();
        set_span(1000, 1000);
        send_temp(16'd1000);
        send_temp(16'd5000);
        settle();
        set_span(32767, -32768);
        send_temp(16'h0000);
        send_temp(16'h7FFF);
        settle();
        set_span(0, 1);
        send_temp(16'h0000);
        send_temp(16'h0001);
        send_temp(16'hFFFF);
    endtask

    task automatic test_flow_no_idle();
        settle();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        set_span(2000, 4000);
        stream_frames(STREAM_END / 4);
    endtask

    task automatic test_sender_gaps();
        int lo;
        settle();
        sender_idle_pct = 61;
        receiver_stall_pct = 0;
        lo = int'($urandom_range(40000)) - 20000;
        set_span(lo, lo + int'($urandom_range(4000, 1)));
        stream_frames(STREAM_END / 2);
    endtask

    task automatic test_receiver_holdoff();
        settle();
        sender_idle_pct = 0;
        receiver_stall_pct = 61;
        set_span(int'($urandom_range(32768)) - 32768, int'($urandom_range(32767)));
        stream_frames(STREAM_END / 2 + 100);
        holdoff_request = 1'b1;
        stream_frames(3 * STREAM_END / 4);
    endtask

    task automatic test_mixed_idle();
        settle();
        sender_idle_pct = 17;
        receiver_stall_pct = 17;
        set_span(int'($urandom_range(65535)) - 32768, int'($urandom_range(65535)) - 32768);
        stream_frames(STREAM_END);
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_rx_byte <= 8'h00;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_defaults();
        test_directed_pixels();
        test_span_edges();
        test_flow_no_idle();
        test_sender_gaps();
        test_receiver_holdoff();
        test_mixed_idle();
        settle();
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
